[rtl/core/mrrs_pkg.sv]
// shared types and constants for the maximal rectangle row scan
package mrrs_pkg;

    localparam int GRID_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF  = 4096;

    localparam int IN_ROW_W   = 32;
    localparam int CFG_W      = 6;
    localparam int OUT_ROW_W  = 13;
    localparam int OUT_COL_W  = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    typedef struct packed {
        logic [IN_ROW_W-1:0] row_bits;
        logic                new_grid;
    } in_item_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] top_row;
        logic [OUT_ROW_W-1:0] bottom_row;
        logic [OUT_COL_W-1:0] left_col;
        logic [OUT_COL_W-1:0] right_col;
        logic                 last_of_row;
    } out_item_t;

    typedef struct packed {
        logic second_pass;
        logic cell_set;
    } col_ctl_t;

endpackage

[rtl/core/mrrs_ram.sv]
// generic single write port ram with registered read
module mrrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/mrrs_col_unit.sv]
// per-column update unit shared by the left and right passes
module mrrs_col_unit #(
    parameter int COL_W    = 6,
    parameter int ROW_W    = 13,
    parameter int MAX_ROWS = 4096
) (
    input  mrrs_pkg::col_ctl_t ctl,
    input  logic [COL_W-1:0]   col_num,
    input  logic [COL_W-1:0]   ncol,
    input  logic [COL_W-1:0]   run_in,
    input  logic [ROW_W-1:0]   row_num,
    input  logic [ROW_W-1:0]   height_in,
    input  logic [COL_W-1:0]   left_in,
    input  logic [COL_W-1:0]   right_in,
    output logic [ROW_W-1:0]   height_out,
    output logic [COL_W-1:0]   left_out,
    output logic [COL_W-1:0]   right_out,
    output logic [COL_W-1:0]   run_out,
    output logic               emit,
    output logic [ROW_W-1:0]   top_out
);

    always_comb begin
        height_out = height_in;
        left_out   = left_in;
        right_out  = right_in;
        run_out    = run_in;
        emit       = 1'b0;
        if (!ctl.second_pass) begin
            if (ctl.cell_set) begin
                if (height_in < ROW_W'(MAX_ROWS)) begin
                    height_out = height_in + ROW_W'(1);
                end
                if (left_in < run_in) begin
                    left_out = run_in;
                end
            end else begin
                height_out = '0;
                left_out   = COL_W'(1);
                run_out    = col_num + COL_W'(1);
            end
        end else begin
            if (ctl.cell_set) begin
                if (right_in > run_in) begin
                    right_out = run_in;
                end
                emit = (right_out >= left_in);
            end else begin
                run_out   = col_num - COL_W'(1);
                right_out = ncol;
            end
        end
    end

    // top row clamps to 1 if the run is taller than the row count
    always_comb begin
        if (height_in > row_num) begin
            top_out = ROW_W'(1);
        end else begin
            top_out = row_num - height_in + ROW_W'(1);
        end
    end

endmodule

[rtl/core/maximal_rectangle_row_scan.sv]
// Row-by-row maximal rectangle scan. Each accepted item is one grid row; the block walks the
// columns in use (c, from cols_in_use clamped to 1..GRID_COLS) twice through one shared column
// unit and one column store: a left-to-right pass updating heights and left bounds, then a
// right-to-left pass updating right bounds and emitting one rectangle per set cell, the last one
// flagged. The store has one read and one write port. A final state after the right pass hands
// over the flagged result, and s_ready stays low from each accepted item until that hand-over;
// a stalled result channel pauses the right pass and the hand-over. s_ready is high only between
// rows. new_grid clears the store through per-column valid bits in the same cycle, so no clearing
// pass follows reset.
module maximal_rectangle_row_scan #(
    parameter int GRID_COLS = mrrs_pkg::GRID_COLS_DEF,
    parameter int MAX_ROWS  = mrrs_pkg::MAX_ROWS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mrrs_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mrrs_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [mrrs_pkg::CFG_W-1:0]       cfg_wr_data
);

    localparam int CW = $clog2(GRID_COLS + 1);
    localparam int AW = $clog2(GRID_COLS);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int EW = RW + 2 * CW;
    localparam int CLR_RESET_I = (GRID_COLS < 32) ? GRID_COLS : 32;
    localparam logic [CW-1:0] CLR_RESET = CW'(CLR_RESET_I);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_FLUSH
    } state_t;

    state_t                     state_reg;
    logic [mrrs_pkg::CFG_W-1:0] cols_in_use_reg;
    logic [GRID_COLS-1:0]       row_reg;
    logic [CW-1:0]              ncol_reg;
    logic [CW-1:0]              clr_c_reg;
    logic [RW-1:0]              row_cnt_reg;
    logic [GRID_COLS-1:0]       vld_reg;
    logic [AW-1:0]              iss_idx_reg;
    logic                       iss_done_reg;
    logic                       s1_vld_reg;
    logic [AW-1:0]              s1_idx_reg;
    logic                       s1_ent_vld_reg;
    logic [CW-1:0]              run_reg;
    logic                       hold_vld_reg;
    mrrs_pkg::out_item_t        hold_reg;
    logic                       m_valid_reg;
    mrrs_pkg::out_item_t        m_data_reg;

    logic [CW-1:0]        eff_cols;
    logic [GRID_COLS-1:0] row_ext;
    logic                 in_fire;
    logic                 p2;
    logic                 m_free;
    logic                 m_load;
    logic                 stall;
    logic                 adv;
    logic                 issue;
    logic                 wr_en;
    logic [AW-1:0]        last_idx;
    logic [EW-1:0]        rd_data;
    logic [RW-1:0]        ent_h;
    logic [CW-1:0]        ent_l;
    logic [CW-1:0]        ent_r;
    mrrs_pkg::col_ctl_t   cu_ctl;
    logic [RW-1:0]        cu_height;
    logic [CW-1:0]        cu_left;
    logic [CW-1:0]        cu_right;
    logic [CW-1:0]        cu_run;
    logic                 cu_emit;
    logic [RW-1:0]        cu_top;
    mrrs_pkg::out_item_t  new_item;
    mrrs_pkg::out_item_t  hold_last;

    always_comb begin
        if (cols_in_use_reg == '0) begin
            eff_cols = CW'(1);
        end else if (int'(cols_in_use_reg) > GRID_COLS) begin
            eff_cols = CW'(GRID_COLS);
        end else begin
            eff_cols = CW'(cols_in_use_reg);
        end
    end

    assign row_ext = GRID_COLS'({{GRID_COLS{1'b0}}, s_data.row_bits});

    assign in_fire  = s_valid && s_ready;
    assign p2       = (state_reg == ST_PASS2);
    assign m_free   = !m_valid_reg || m_ready;
    assign stall    = p2 && s1_vld_reg && cu_emit && hold_vld_reg && !m_free;
    assign adv      = !stall;
    assign issue    = ((state_reg == ST_PASS1) || p2) && !iss_done_reg;
    assign wr_en    = s1_vld_reg && adv;
    assign last_idx = p2 ? '0 : AW'(ncol_reg - CW'(1));
    assign m_load   = (wr_en && p2 && cu_emit && hold_vld_reg)
                      || ((state_reg == ST_FLUSH) && hold_vld_reg && m_free);

    // entries not written since the last clear read as the cleared value
    assign ent_h = s1_ent_vld_reg ? rd_data[EW-1 -: RW] : '0;
    assign ent_l = s1_ent_vld_reg ? rd_data[2*CW-1 -: CW] : '0;
    assign ent_r = s1_ent_vld_reg ? rd_data[CW-1:0] : clr_c_reg;

    assign cu_ctl.second_pass = p2;
    assign cu_ctl.cell_set    = row_reg[s1_idx_reg];

    mrrs_ram #(
        .WIDTH(EW),
        .DEPTH(GRID_COLS)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(s1_idx_reg),
        .wr_data({cu_height, cu_left, cu_right}),
        .rd_en  (adv),
        .rd_addr(iss_idx_reg),
        .rd_data(rd_data)
    );

    mrrs_col_unit #(
        .COL_W   (CW),
        .ROW_W   (RW),
        .MAX_ROWS(MAX_ROWS)
    ) u_col (
        .ctl       (cu_ctl),
        .col_num   (CW'(s1_idx_reg) + CW'(1)),
        .ncol      (ncol_reg),
        .run_in    (run_reg),
        .row_num   (row_cnt_reg),
        .height_in (ent_h),
        .left_in   (ent_l),
        .right_in  (ent_r),
        .height_out(cu_height),
        .left_out  (cu_left),
        .right_out (cu_right),
        .run_out   (cu_run),
        .emit      (cu_emit),
        .top_out   (cu_top)
    );

    always_comb begin
        new_item.top_row     = mrrs_pkg::OUT_ROW_W'(cu_top);
        new_item.bottom_row  = mrrs_pkg::OUT_ROW_W'(row_cnt_reg);
        new_item.left_col    = mrrs_pkg::OUT_COL_W'(ent_l);
        new_item.right_col   = mrrs_pkg::OUT_COL_W'(cu_right);
        new_item.last_of_row = 1'b0;
        hold_last             = hold_reg;
        hold_last.last_of_row = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cols_in_use_reg <= mrrs_pkg::CFG_RESET;
            clr_c_reg       <= CLR_RESET;
            row_cnt_reg     <= '0;
            vld_reg         <= '0;
            iss_done_reg    <= 1'b1;
            s1_vld_reg      <= 1'b0;
            hold_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cols_in_use_reg <= cfg_wr_data;
            end

            if (adv) begin
                s1_vld_reg     <= issue;
                s1_idx_reg     <= iss_idx_reg;
                s1_ent_vld_reg <= vld_reg[iss_idx_reg];
            end

            if (wr_en) begin
                vld_reg[s1_idx_reg] <= 1'b1;
                run_reg             <= cu_run;
            end

            if (issue && adv) begin
                if (iss_idx_reg == last_idx) begin
                    iss_done_reg <= 1'b1;
                end else if (p2) begin
                    iss_idx_reg <= iss_idx_reg - AW'(1);
                end else begin
                    iss_idx_reg <= iss_idx_reg + AW'(1);
                end
            end

            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // one result waits in hold so the row's final item can be flagged
            if (wr_en && p2 && cu_emit) begin
                if (hold_vld_reg) begin
                    m_data_reg <= hold_reg;
                end
                hold_reg     <= new_item;
                hold_vld_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        row_reg  <= row_ext;
                        ncol_reg <= eff_cols;
                        if (s_data.new_grid) begin
                            vld_reg     <= '0;
                            clr_c_reg   <= eff_cols;
                            row_cnt_reg <= RW'(1);
                        end else if (row_cnt_reg < RW'(MAX_ROWS)) begin
                            row_cnt_reg <= row_cnt_reg + RW'(1);
                        end
                        iss_idx_reg  <= '0;
                        iss_done_reg <= 1'b0;
                        run_reg      <= CW'(1);
                        state_reg    <= ST_PASS1;
                    end
                end
                ST_PASS1: begin
                    // wait for the last write before reading back from the right end
                    if (iss_done_reg && !s1_vld_reg) begin
                        iss_idx_reg  <= AW'(ncol_reg - CW'(1));
                        iss_done_reg <= 1'b0;
                        run_reg      <= ncol_reg;
                        state_reg    <= ST_PASS2;
                    end
                end
                ST_PASS2: begin
                    if (iss_done_reg && !s1_vld_reg) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (!hold_vld_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (m_free) begin
                        m_data_reg   <= hold_last;
                        hold_vld_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/mrrs_checker.sv]
// port-level checks for the maximal rectangle row scan, bound to the top level
module mrrs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mrrs_pkg::out_item_t m_data
);

    // a held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // taking a row makes the block busy, so ready is low in the cycle after
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after taking an item");

    // rectangle bounds are ordered and nonzero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.top_row != '0) && (m_data.top_row <= m_data.bottom_row)
                    && (m_data.left_col != '0) && (m_data.left_col <= m_data.right_col))
        else $error("rectangle bounds out of order");

    // an item that is not the last of its row is followed by one from the same row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_of_row) ##1 m_valid
            |-> m_data.bottom_row == $past(m_data.bottom_row))
        else $error("row changed before last item");

endmodule

bind maximal_rectangle_row_scan mrrs_checker u_mrrs_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
